@@ sv/sfcb_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcb_pkg
// Constants, types and frame byte lookup for the serial frame command bridge.
// ----------------------------------------------------------------------------
package sfcb_pkg;

	localparam logic [7:0]  HDR_B0      = 8'hA4;
	localparam logic [7:0]  HDR_B1      = 8'h00;
	localparam logic [7:0]  HDR_B2      = 8'h00;
	localparam logic [7:0]  HDR_B3      = 8'h01;
	localparam logic [7:0]  TRAILER     = 8'h44;
	localparam logic [7:0]  ERR_CHAR0   = 8'h30;
	localparam logic [7:0]  ERR_CHARF   = 8'h46;

	localparam logic [31:0] BIT23_OFF   = 32'hFF7F_FFFF;
	localparam logic [31:0] CMD_RESET   = 32'h0080_0000;
	localparam logic [31:0] CMD_RESET2  = 32'h0080_0001;
	localparam logic [31:0] CMD_BITERR  = 32'h0680_0000;
	localparam logic [31:0] CMD_BITDONE = 32'h0580_0000;
	localparam logic [31:0] CMD_LOG     = 32'h0480_0001;
	localparam logic [31:0] CMD_LOGSTB  = 32'h0481_0000;
	localparam logic [31:0] CMD_LOGDONE = 32'h0480_0000;

	localparam logic [15:0] LOG_COUNT_RST = 16'd900;
	localparam logic [15:0] BITERR_COUNT  = 16'd8;
	localparam logic [3:0]  LAST_POS      = 4'd8;
	localparam logic [3:0]  ERR_LEN       = 4'd7;
	localparam logic [3:0]  DATA_LEN      = 4'd9;

	localparam int          APB_AW      = 4;
	localparam logic [1:0]  REG_LOG_COUNT = 2'd0;

	typedef enum logic [2:0] {
		RB_IDLE = 3'b001,
		RB_BIT  = 3'b010,
		RB_LOG  = 3'b100
	} rb_mode_t;

	typedef struct packed {
		logic        err_frame;
		logic [3:0]  nbytes;
		logic [3:0]  total;
		logic [31:0] rd_word;
		logic [31:0] w1;
		logic [31:0] w2;
	} desc_t;

	function automatic logic [7:0] frame_byte(input logic err, input logic [3:0] pos,
		input logic [31:0] w);
		logic [7:0] b;
		unique case (pos)
			4'd0: b = HDR_B0;
			4'd1: b = HDR_B1;
			4'd2: b = HDR_B2;
			4'd3: b = HDR_B3;
			4'd4: b = err ? ERR_CHAR0 : w[7:0];
			4'd5: b = err ? ERR_CHARF : w[15:8];
			4'd6: b = err ? TRAILER : w[23:16];
			4'd7: b = w[31:24];
			default: b = TRAILER;
		endcase
		return b;
	endfunction

endpackage

@@ sv/serial_frame_command_bridge.sv @@
// After acceptance, an item's descriptor is registered and its first result is then loaded into the output register.
// An item occupies the result sequencer until all of its results (up to 12) have been loaded;
// items with no result are taken every cycle while the result sequencer is idle.
// The next item is accepted in the cycle the previous item's last result is loaded.
// Reset (arst_n low) clears frame, readback and output state; log_count returns to 900.
// ----------------------------------------------------------------------------
// serial_frame_command_bridge
// Parses serial command frames, issues port write triples and frames read words.
// ----------------------------------------------------------------------------
module serial_frame_command_bridge
	import sfcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // rx_byte[7:0], read_word[39:8]
	input  logic              s_tuser,   // action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // port_word[31:0], tx_byte[39:32]
	output logic              m_tuser,   // kind
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [15:0] log_count_q;
	logic [3:0]  frame_pos_q, frame_pos_d;
	logic        err_q, err_d;
	logic [31:0] cmd_q, cmd_d;
	rb_mode_t    rb_q, rb_d;
	logic [15:0] rb_idx_q, rb_idx_d;

	desc_t       desc_q, desc_d;
	logic        desc_valid_q;
	logic [3:0]  pos_q;
	logic        has_res;

	logic        m_tvalid_q, m_kind_q, m_last_q;
	logic [31:0] m_word_q;
	logic [7:0]  m_byte_q;

	logic        in_acc, emit, elem_last, in_bytes, clr23;
	logic [7:0]  rx_byte;
	logic [31:0] read_word;
	logic [15:0] idx_n, limit;
	logic [3:0]  j;
	logic [31:0] tw;
	logic [7:0]  fb;

	assign rx_byte   = s_tdata[7:0];
	assign read_word = s_tdata[39:8];
	assign pready    = 1'b1;
	assign prdata    = (paddr[APB_AW-1:2] == REG_LOG_COUNT) ? {16'd0, log_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_count_q <= LOG_COUNT_RST;
		end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_LOG_COUNT) begin
			log_count_q <= pwdata[15:0];
		end
	end

	assign emit      = desc_valid_q && (!m_tvalid_q || m_tready);
	assign elem_last = pos_q == desc_q.total - 4'd1;
	assign s_tready  = !desc_valid_q || (emit && elem_last);
	assign in_acc    = s_tvalid && s_tready;

	assign idx_n = rb_idx_q + 16'd1;
	assign limit = (rb_q == RB_BIT) ? BITERR_COUNT : log_count_q;

	always_comb begin
		frame_pos_d = frame_pos_q;
		err_d       = err_q;
		cmd_d       = cmd_q;
		rb_d        = rb_q;
		rb_idx_d    = rb_idx_q;
		has_res     = 1'b0;
		desc_d      = '0;
		if (rb_q == RB_IDLE) begin
			if (!s_tuser) begin
				unique case (frame_pos_q)
					4'd0: if (rx_byte != HDR_B0) err_d = 1'b1;
					4'd1, 4'd2: if (rx_byte != HDR_B1) err_d = 1'b1;
					4'd3: if (rx_byte != HDR_B3) err_d = 1'b1;
					4'd4, 4'd5, 4'd6, 4'd7: cmd_d = {cmd_q[23:0], rx_byte};
					default: begin
						has_res = 1'b1;
						if (rx_byte != TRAILER || err_q) begin
							desc_d.err_frame = 1'b1;
							desc_d.nbytes    = ERR_LEN;
							desc_d.total     = ERR_LEN;
						end else begin
							desc_d.total = 4'd3;
							priority if (cmd_q == CMD_BITERR) begin
								rb_d     = RB_BIT;
								rb_idx_d = '0;
								desc_d.w1 = CMD_BITERR;
							end else if (cmd_q == CMD_LOG) begin
								rb_idx_d = '0;
								if (log_count_q == '0) begin
									desc_d.w1 = CMD_LOGDONE;
								end else begin
									rb_d      = RB_LOG;
									desc_d.w1 = CMD_LOGSTB;
								end
							end else if (cmd_q == CMD_RESET) begin
								desc_d.w1    = cmd_q;
								desc_d.w2    = CMD_RESET2;
								desc_d.total = 4'd6;
							end else begin
								desc_d.w1 = cmd_q;
							end
						end
					end
				endcase
				if (frame_pos_q >= LAST_POS) begin
					frame_pos_d = '0;
					err_d       = 1'b0;
				end else begin
					frame_pos_d = frame_pos_q + 4'd1;
				end
			end
		end else if (s_tuser) begin
			has_res        = 1'b1;
			desc_d.rd_word = read_word;
			desc_d.nbytes  = DATA_LEN;
			desc_d.total   = DATA_LEN + 4'd3;
			if (idx_n != '0 && idx_n < limit) begin
				rb_idx_d  = idx_n;
				desc_d.w1 = (rb_q == RB_BIT) ? (CMD_BITERR | {28'd0, idx_n[3:0]})
				                             : (CMD_LOGSTB | {16'd0, idx_n});
			end else begin
				desc_d.w1 = (rb_q == RB_BIT) ? CMD_BITDONE : CMD_LOGDONE;
				rb_d      = RB_IDLE;
				rb_idx_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
			err_q       <= 1'b0;
			cmd_q       <= '0;
			rb_q        <= RB_IDLE;
			rb_idx_q    <= '0;
		end else if (in_acc) begin
			frame_pos_q <= frame_pos_d;
			err_q       <= err_d;
			cmd_q       <= cmd_d;
			rb_q        <= rb_d;
			rb_idx_q    <= rb_idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_valid_q <= 1'b0;
			pos_q        <= '0;
		end else if (in_acc && has_res) begin
			desc_valid_q <= 1'b1;
			pos_q        <= '0;
		end else if (emit) begin
			if (elem_last) desc_valid_q <= 1'b0;
			pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) desc_q <= desc_d;
	end

	assign in_bytes = pos_q < desc_q.nbytes;
	assign j        = pos_q - desc_q.nbytes;
	assign tw       = (j >= 4'd3) ? desc_q.w2 : desc_q.w1;
	assign clr23    = !(j == 4'd1 || j == 4'd4);
	assign fb       = frame_byte(desc_q.err_frame, pos_q, desc_q.rd_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_kind_q <= in_bytes;
			m_last_q <= elem_last;
			m_byte_q <= in_bytes ? fb : 8'd0;
			m_word_q <= in_bytes ? 32'd0 : (clr23 ? (tw & BIT23_OFF) : tw);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_byte_q, m_word_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid_q |-> pos_q < desc_q.total)
		else $error("result position past end of sequence");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos_q <= LAST_POS)
		else $error("frame position out of range");

	a_rb_frame_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rb_q != RB_IDLE |-> frame_pos_q == '0)
		else $error("readback entered mid-frame");

	a_bit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rb_q == RB_BIT |-> rb_idx_q < BITERR_COUNT)
		else $error("bit-error index out of range");

	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && has_res) |=> desc_valid_q && pos_q == '0)
		else $error("new sequence not started");

endmodule
